@@ design/hpq_pkg.sv @@
// Shared types and constants for the min-heap priority queue.
package hpq_pkg;

	localparam int CNT_W         = 7;
	localparam int CNT_MAX       = (1 << CNT_W) - 1;
	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 32;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_FINAL,
		S_EXT,
		S_DOWN,
		S_RESULT
	} hpq_state_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count;
	} hpq_res_t;

endpackage

@@ design/hpq_mem.sv @@
// Heap key storage: one write port, two registered read ports.
module hpq_mem import hpq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [KEY_WIDTH-1:0] wdata,
	input  logic [AW-1:0]        raddr0,
	input  logic [AW-1:0]        raddr1,
	output logic [KEY_WIDTH-1:0] rdata0,
	output logic [KEY_WIDTH-1:0] rdata1
);

	logic [KEY_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

@@ design/hpq_ctrl.sv @@
// Heap sequencer: insert sift-up and extract sift-down over the key memory.
module hpq_ctrl import hpq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic signed [KEY_WIDTH-1:0] in_key,
	input  logic [CNT_W-1:0]            limit,
	input  logic                        res_free,
	output logic                        res_push,
	output logic [KEY_WIDTH-1:0]        res_key,
	output hpq_res_t                    res_info,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [KEY_WIDTH-1:0]        mem_wdata,
	output logic [AW-1:0]               mem_raddr0,
	output logic [AW-1:0]               mem_raddr1,
	input  logic [KEY_WIDTH-1:0]        mem_rdata0,
	input  logic [KEY_WIDTH-1:0]        mem_rdata1
);

	// position width: covers both children of any held entry
	localparam int IW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

	hpq_state_t state_q, state_d;

	logic [CNT_W-1:0]            cnt_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic [IW-1:0]               pos_q;
	logic [KEY_WIDTH-1:0]        res_key_q;
	status_t                     res_status_q;

	logic signed [KEY_WIDTH-1:0] rd0, rd1, best_v, dn_v;
	logic [IW-1:0] cnt_ext, cnt_m1, ins_par, pos_m1, par_pos, pp_m1, par_par;
	logic [IW-1:0] lc, rc, dn_idx, dn_lc, dn_rc;
	logic          up_gt, sel_l, sel_r, dn_move, full, empty, accept;

	always_comb begin
		rd0     = $signed(mem_rdata0);
		rd1     = $signed(mem_rdata1);
		cnt_ext = IW'(cnt_q);
		cnt_m1  = cnt_ext - 1'b1;
		ins_par = cnt_m1 >> 1;
		pos_m1  = pos_q - 1'b1;
		par_pos = pos_m1 >> 1;
		pp_m1   = par_pos - 1'b1;
		par_par = pp_m1 >> 1;
		up_gt   = rd0 > key_q;
		lc      = {pos_q[IW-2:0], 1'b1};
		rc      = lc + 1'b1;
		sel_l   = (lc < cnt_ext) && (rd0 < key_q);
		best_v  = sel_l ? rd0 : key_q;
		sel_r   = (rc < cnt_ext) && (rd1 < best_v);
		dn_move = sel_l | sel_r;
		dn_idx  = sel_r ? rc : lc;
		dn_v    = sel_r ? rd1 : rd0;
		dn_lc   = {dn_idx[IW-2:0], 1'b1};
		dn_rc   = dn_lc + 1'b1;
		full    = cnt_q >= limit;
		empty   = cnt_q == '0;
		accept  = in_valid && (state_q == S_IDLE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_INSERT) begin
						state_d = (full || empty) ? S_RESULT : S_UP;
					end else begin
						state_d = empty ? S_RESULT : S_EXT;
					end
				end
			end
			S_EXT:    state_d = empty ? S_RESULT : S_DOWN;
			S_UP: begin
				if (!up_gt) begin
					state_d = S_RESULT;
				end else if (par_pos == '0) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL:  state_d = S_RESULT;
			S_DOWN:   state_d = dn_move ? S_DOWN : S_RESULT;
			S_RESULT: state_d = res_free ? S_IDLE : S_RESULT;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory requests and result handoff
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = pos_q[AW-1:0];
		mem_wdata  = key_q;
		mem_raddr0 = '0;
		mem_raddr1 = '0;
		res_push   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_op == OP_INSERT) begin
					mem_raddr0 = ins_par[AW-1:0];
				end
				mem_raddr1 = cnt_m1[AW-1:0];
				mem_waddr  = '0;
				mem_wdata  = in_key;
				mem_we     = accept && (in_op == OP_INSERT) && !full && empty;
			end
			S_EXT: begin
				mem_raddr0 = AW'(1);
				mem_raddr1 = AW'(2);
			end
			S_UP: begin
				mem_we     = 1'b1;
				mem_wdata  = up_gt ? rd0 : key_q;
				mem_raddr0 = par_par[AW-1:0];
			end
			S_FINAL: begin
				mem_we = 1'b1;
			end
			S_DOWN: begin
				mem_we     = 1'b1;
				mem_wdata  = dn_move ? dn_v : key_q;
				mem_raddr0 = dn_lc[AW-1:0];
				mem_raddr1 = dn_rc[AW-1:0];
			end
			S_RESULT: begin
				res_push = res_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (in_op == OP_INSERT && !full) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (in_op == OP_EXTRACT && !empty) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q <= in_key;
					pos_q <= cnt_ext;
					if (in_op == OP_INSERT) begin
						res_key_q    <= '0;
						res_status_q <= full ? STATUS_FULL : STATUS_OK;
					end else begin
						res_key_q    <= KEY_MAX;
						res_status_q <= empty ? STATUS_EMPTY : STATUS_OK;
					end
				end
			end
			S_EXT: begin
				res_key_q <= mem_rdata0;
				key_q     <= rd1;
				pos_q     <= '0;
			end
			S_UP: begin
				if (up_gt) begin
					pos_q <= par_pos;
				end
			end
			S_DOWN: begin
				if (dn_move) begin
					pos_q <= dn_idx;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign in_ready        = state_q == S_IDLE;
	assign res_key         = res_key_q;
	assign res_info.status = res_status_q;
	assign res_info.count  = cnt_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		IW'(cnt_q) <= IW'(DEPTH))
		else $error("entry count above depth");
	a_pos_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP || state_q == S_DOWN || state_q == S_FINAL) |-> pos_q < cnt_ext)
		else $error("sift position outside held entries");
	a_up_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UP |-> pos_q != '0)
		else $error("sift-up at root");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("transfer accepted without starting work");
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> state_q == S_IDLE)
		else $error("result pushed without returning idle");
`endif

endmodule

@@ design/min_heap_priority_queue.sv @@
// Min-heap priority queue top level: config register, output register, core.
//
// Input stream (s_axis_*): tuser is the opcode (0 insert, 1 extract minimum),
// tdata carries the signed key for an insert. Output stream (m_axis_*): one
// result per input transfer, in order; tdata holds the key (minimum extracted,
// largest key on an empty heap, zero for insert) and the count after the
// operation; tuser holds the status (0 ok, 1 insert dropped full, 2 empty).
// Config channel (cfg_*): the capacity limit, to be written by the user only
// while idle; the block itself does not enforce this. Keys live in a
// dual-read, single-write memory with registered reads; the sequencer walks
// one heap level per cycle, so the result comes soonest for a dropped insert,
// an empty extract or an insert into an empty heap, and latest for a sift
// across all levels, set by the one-read-per-level memory loop. One item is
// worked at a time; the next is taken once the current result is handed to
// the output register, which holds it while m_axis_tready is low.
// Reset empties the heap and sets the capacity limit to 64; memory contents
// are not cleared, and the first transfer can be taken straight after reset.
module min_heap_priority_queue import hpq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int IN_DW    = ((KEY_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW   = ((KEY_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,   // key_in
	input  logic              s_axis_tuser,   // opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata,   // key_out, count
	output logic [1:0]        m_axis_tuser,   // status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data        // capacity_limit
);

	localparam int DEPTH_CAP = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH_DEF);

	logic [CNT_W-1:0]     cap_q, limit;
	logic                 out_valid_q, res_free, res_push;
	logic [KEY_WIDTH-1:0] res_key, out_key_q;
	hpq_res_t             res_info, out_info_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, mem_raddr0, mem_raddr1;
	logic [KEY_WIDTH-1:0] mem_wdata, mem_rdata0, mem_rdata1;

	assign cfg_ready = 1'b1;
	assign limit     = (cap_q > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : cap_q;
	assign res_free  = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (res_push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_key_q  <= res_key;
			out_info_q <= res_info;
		end
	end

	always_comb begin
		m_axis_tdata                       = '0;
		m_axis_tdata[KEY_WIDTH-1:0]        = out_key_q;
		m_axis_tdata[KEY_WIDTH +: CNT_W]   = out_info_q.count;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_info_q.status;

	hpq_ctrl #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_key     ($signed(s_axis_tdata[KEY_WIDTH-1:0])),
		.limit      (limit),
		.res_free   (res_free),
		.res_push   (res_push),
		.res_key    (res_key),
		.res_info   (res_info),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.mem_rdata0 (mem_rdata0),
		.mem_rdata1 (mem_rdata1)
	);

	hpq_mem #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (mem_rdata0),
		.rdata1 (mem_rdata1)
	);

endmodule

@@ test/tb_top.sv @@
// Testbench for the min-heap priority queue: inserts and extracts checked against a heap predictor.
`timescale 1ns / 1ps

module tb_top import hpq_pkg::*;;

	localparam int HEAP_DEPTH = DEPTH_DEF;
	localparam int TIMEOUT_NS = 7_200_000;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic [31:0]      key;
		status_t          status;
		logic [CNT_W-1:0] count;
	} heap_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata = '0;   // key_in
	logic             s_axis_tuser = 1'b0; // opcode
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [39:0]      m_axis_tdata;        // key_out, count
	logic [1:0]       m_axis_tuser;        // status
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	heap_result_t       expected_results[$];
	logic signed [31:0] heap_keys [HEAP_DEPTH];
	int                 heap_size = 0;
	int                 capacity_model = 64;
	int                 error_count = 0;
	int                 mismatch_count = 0;
	bit                 idle_gaps = 1'b1;
	int                 rx_hold_cycles = 0;

	min_heap_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one operation to the heap copy and returns the result it yields.
	function automatic heap_result_t heap_apply(input logic op, input logic signed [31:0] key);
		heap_result_t       r;
		int                 limit;
		int                 pos;
		int                 parent;
		int                 lc;
		int                 rc;
		int                 best;
		logic signed [31:0] tmp;
		r.key = '0;
		r.status = STATUS_OK;
		limit = (capacity_model < HEAP_DEPTH) ? capacity_model : HEAP_DEPTH;
		if (op == OP_INSERT) begin
			if (heap_size >= limit) begin
				r.status = STATUS_FULL;
			end else begin
				pos = heap_size;
				heap_keys[pos] = key;
				heap_size++;
				while (pos != 0) begin
					parent = (pos - 1) / 2;
					if (heap_keys[parent] <= heap_keys[pos])
						break;
					tmp = heap_keys[parent];
					heap_keys[parent] = heap_keys[pos];
					heap_keys[pos] = tmp;
					pos = parent;
				end
			end
		end else if (heap_size == 0) begin
			r.key = KEY_MAX;
			r.status = STATUS_EMPTY;
		end else begin
			r.key = heap_keys[0];
			heap_size--;
			if (heap_size > 0) begin
				heap_keys[0] = heap_keys[heap_size];
				pos = 0;
				while (1) begin
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					best = pos;
					if (lc < heap_size && heap_keys[lc] < heap_keys[best])
						best = lc;
					if (rc < heap_size && heap_keys[rc] < heap_keys[best])
						best = rc;
					if (best == pos)
						break;
					tmp = heap_keys[best];
					heap_keys[best] = heap_keys[pos];
					heap_keys[pos] = tmp;
					pos = best;
				end
			end
		end
		r.count = heap_size[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [31:0] random_key();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return KEY_MIN;
					1: return KEY_MAX;
					2: return 32'd0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input logic op, input logic [31:0] key);
		int gap;
		gap = idle_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= key;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(heap_apply(op, key));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_model = value & CNT_MAX;
	endtask

	task automatic test_empty_heap();
		send_op(OP_EXTRACT, $urandom);
		send_op(OP_EXTRACT, 32'hFFFF_FFFF);
	endtask

	task automatic test_key_extremes();
		send_op(OP_INSERT, KEY_MAX);
		send_op(OP_INSERT, KEY_MIN);
		send_op(OP_INSERT, 32'd0);
		send_op(OP_INSERT, 32'hFFFF_FFFF);
		send_op(OP_INSERT, KEY_MAX);
		repeat (6) send_op(OP_EXTRACT, $urandom);
	endtask

	task automatic test_capacity_edges();
		write_capacity(1);
		send_op(OP_INSERT, 32'd3);
		send_op(OP_INSERT, 32'd4);
		send_op(OP_EXTRACT, 32'd0);
		write_capacity(0);
		send_op(OP_INSERT, 32'd7);
		// refill to four entries, then shrink the limit below the current count
		write_capacity(64);
		repeat (4) send_op(OP_INSERT, random_key());
		write_capacity(2);
		send_op(OP_INSERT, random_key());
		repeat (3) send_op(OP_EXTRACT, $urandom);
		send_op(OP_INSERT, random_key());
	endtask

	task automatic test_random_mix();
		int caps [9] = '{64, 127, 5, 1, 64, 0, 2, 37, 64};
		int n_items;
		int insert_pct;
		for (int p = 0; p < 9; p++) begin
			write_capacity((p == 7) ? $urandom_range(1, 64) : caps[p]);
			idle_gaps = (p % 3 != 2);
			n_items = (caps[p] == 0) ? 20 : 235;
			for (int i = 0; i < n_items; i++) begin
				// long insert-heavy runs fill the heap, extract-heavy runs empty it
				insert_pct = ((i / 50) % 2 == 0) ? 90 : 25;
				send_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
					random_key());
			end
		end
		idle_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		write_capacity(64);
		idle_gaps = 1'b0;
		rx_hold_cycles = 300;
		repeat (40)
			send_op(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_EXTRACT, random_key());
		wait_drained();
		idle_gaps = 1'b1;
		repeat (20)
			send_op(($urandom_range(0, 99) < 50) ? OP_INSERT : OP_EXTRACT, random_key());
	endtask

	initial begin : result_sink
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				wait_cycles = idle_gaps ? $urandom_range(0, 9) : 0;
				if (wait_cycles > 0) begin
					m_axis_tready <= 1'b0;
					repeat (wait_cycles) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				do @(posedge clk); while (!m_axis_tvalid && rx_hold_cycles == 0);
			end
		end
	end

	always @(posedge clk) begin : check_results
		heap_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (mismatch_count < 10)
					$display("unexpected result transfer: key %0d status %0d count %0d",
						$signed(m_axis_tdata[31:0]), m_axis_tuser, m_axis_tdata[38:32]);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== want.key || m_axis_tuser !== want.status
						|| m_axis_tdata[38:32] !== want.count) begin
					error_count++;
					if (mismatch_count < 10)
						$display("mismatch: key exp %0d got %0d, status exp %0d got %0d, count exp %0d got %0d",
							$signed(want.key), $signed(m_axis_tdata[31:0]), want.status,
							m_axis_tuser, want.count, m_axis_tdata[38:32]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_heap();
		test_key_extremes();
		test_capacity_edges();
		test_backpressure();
		test_random_mix();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ min_heap_priority_queue.f @@
design/hpq_pkg.sv
design/hpq_mem.sv
design/hpq_ctrl.sv
design/min_heap_priority_queue.sv
test/tb_top.sv
